[rtl/blm_pkg.sv]
package blm_pkg;

   localparam int unsigned NUM_BITS = 17;
   localparam int unsigned DEN_BITS = 8;

   localparam logic [4:0] MODE_NORMAL   = 5'd0;
   localparam logic [4:0] MODE_DARKEN   = 5'd1;
   localparam logic [4:0] MODE_MULTIPLY = 5'd2;
   localparam logic [4:0] MODE_BURN     = 5'd3;
   localparam logic [4:0] MODE_LINBURN  = 5'd4;
   localparam logic [4:0] MODE_LIGHTEN  = 5'd5;
   localparam logic [4:0] MODE_SCREEN   = 5'd6;
   localparam logic [4:0] MODE_DODGE    = 5'd7;
   localparam logic [4:0] MODE_LINDODGE = 5'd8;
   localparam logic [4:0] MODE_OVERLAY  = 5'd9;
   localparam logic [4:0] MODE_SOFT     = 5'd10;
   localparam logic [4:0] MODE_HARD     = 5'd11;
   localparam logic [4:0] MODE_LINLIGHT = 5'd12;
   localparam logic [4:0] MODE_PIN      = 5'd13;
   localparam logic [4:0] MODE_HARDMIX  = 5'd14;
   localparam logic [4:0] MODE_DIFF     = 5'd15;
   localparam logic [4:0] MODE_EXCL     = 5'd16;
   localparam logic [4:0] MODE_DIVIDE   = 5'd17;

   // what the final stage does with the quotient
   localparam logic [2:0] OP_DIRECT    = 3'd0;
   localparam logic [2:0] OP_CLAMP     = 3'd1;
   localparam logic [2:0] OP_INV       = 3'd2;
   localparam logic [2:0] OP_MIX_CLAMP = 3'd3;
   localparam logic [2:0] OP_MIX_INV   = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] direct;
   } chan_ctl_type;

endpackage

[rtl/blm_prep.sv]
module blm_prep (
   input  logic [4:0]            mode,
   input  logic                  same,
   input  logic [7:0]            a,
   input  logic [7:0]            b,
   output logic [16:0]           num,
   output logic [7:0]            den,
   output blm_pkg::chan_ctl_type ctl
);
   import blm_pkg::*;

   logic [7:0]  inv_a;
   logic [7:0]  inv_b;
   logic [8:0]  sum_ab;
   logic [15:0] prod_ab;
   logic [15:0] prod_inv;
   logic [7:0]  soft_h;
   logic [7:0]  soft_inv_h;
   logic [15:0] prod_hb;
   logic [15:0] prod_hinv;
   logic [9:0]  lin_sum;
   logic [8:0]  two_b;
   logic [8:0]  pin_lo;
   logic [8:0]  pin_hi;
   logic [16:0] ovl_lo;
   logic [16:0] ovl_hi;
   logic [8:0]  viv_den;

   // invert at 8 bits before widening into the products
   assign inv_a      = ~a;
   assign inv_b      = ~b;
   assign sum_ab     = {1'b0, a} + {1'b0, b};
   assign prod_ab    = a * b;
   assign prod_inv   = inv_a * inv_b;
   assign soft_h     = {1'b0, a[7:1]} + 8'd64;
   assign soft_inv_h = 8'd255 - soft_h;
   assign prod_hb    = soft_h * b;
   assign prod_hinv  = soft_inv_h * inv_b;
   assign lin_sum    = {2'b00, a} + {1'b0, b, 1'b0};
   assign two_b      = {b, 1'b0};
   assign pin_lo     = ({1'b0, a} < two_b) ? {1'b0, a} : two_b;
   assign pin_hi     = two_b - 9'd255;
   assign ovl_lo     = ({1'b0, prod_ab} + 17'd64) >> 7;
   assign ovl_hi     = (17'd32704 - {1'b0, prod_inv}) >> 7;
   assign viv_den    = 9'd509 - two_b;

   always_comb begin
      num        = '0;
      den        = 8'd1;
      ctl.op     = OP_DIRECT;
      ctl.direct = b;
      if (!same) begin
         case (mode)
            MODE_DARKEN: ctl.direct = (a < b) ? a : b;
            MODE_MULTIPLY: begin
               ctl.op = OP_CLAMP;
               num    = {1'b0, prod_ab};
               den    = 8'd255;
            end
            MODE_BURN: begin
               if (b == 8'd0) begin
                  ctl.direct = 8'd0;
               end else begin
                  ctl.op = OP_INV;
                  num    = {1'b0, ~a, 8'd0};
                  den    = b;
               end
            end
            MODE_LINBURN: ctl.direct = (sum_ab >= 9'd255) ? 8'(sum_ab - 9'd255) : 8'd0;
            MODE_LIGHTEN: ctl.direct = (a > b) ? a : b;
            MODE_SCREEN: ctl.direct = ~prod_inv[15:8];
            MODE_DODGE: begin
               if (b == 8'd255) begin
                  ctl.direct = 8'd255;
               end else begin
                  ctl.op = OP_CLAMP;
                  num    = {1'b0, a, 8'd0};
                  den    = ~b;
               end
            end
            MODE_LINDODGE: ctl.direct = sum_ab[8] ? 8'd255 : sum_ab[7:0];
            MODE_OVERLAY: ctl.direct = a[7] ? ovl_hi[7:0] : ovl_lo[7:0];
            MODE_SOFT: begin
               den = 8'd255;
               if (b < 8'd127) begin
                  ctl.op = OP_CLAMP;
                  num    = {prod_hb, 1'b0};
               end else begin
                  ctl.op = OP_INV;
                  num    = {prod_hinv, 1'b0} + 17'd254;
               end
            end
            MODE_HARD: begin
               den = 8'd255;
               if (!b[7]) begin
                  ctl.op = OP_CLAMP;
                  num    = {prod_ab, 1'b0};
               end else begin
                  ctl.op = OP_INV;
                  num    = {prod_inv, 1'b0} + 17'd254;
               end
            end
            MODE_LINLIGHT: begin
               if (lin_sum < 10'd255)      ctl.direct = 8'd0;
               else if (lin_sum > 10'd510) ctl.direct = 8'd255;
               else                        ctl.direct = 8'(lin_sum - 10'd255);
            end
            MODE_PIN: begin
               if (two_b[8] && (pin_hi > pin_lo)) ctl.direct = pin_hi[7:0];
               else                              ctl.direct = pin_lo[7:0];
            end
            MODE_HARDMIX: begin
               if (b < 8'd127) begin
                  if (b == 8'd0) begin
                     ctl.direct = 8'd0;
                  end else begin
                     ctl.op = OP_MIX_INV;
                     num    = {1'b0, ~a, 8'd0} + {8'd0, two_b} - 17'd1;
                     den    = two_b[7:0];
                  end
               end else if (b == 8'd255) begin
                  ctl.direct = 8'd255;
               end else begin
                  ctl.op = OP_MIX_CLAMP;
                  num    = {1'b0, a, 8'd0};
                  den    = viv_den[7:0];
               end
            end
            MODE_DIFF: ctl.direct = (a > b) ? (a - b) : (b - a);
            MODE_EXCL: begin
               ctl.op = OP_CLAMP;
               num    = {sum_ab, 8'd0} - {8'd0, sum_ab} - {prod_ab, 1'b0};
               den    = 8'd255;
            end
            MODE_DIVIDE: begin
               if (b == 8'd0) begin
                  ctl.direct = 8'd255;
               end else begin
                  ctl.op = OP_CLAMP;
                  num    = {1'b0, a, 8'd0} - {9'd0, a};
                  den    = b;
               end
            end
            default: ctl.direct = b;
         endcase
      end
   end

endmodule

[rtl/blm_div.sv]
module blm_div (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [16:0]           num,
   input  logic [7:0]            den,
   input  blm_pkg::chan_ctl_type ctl,
   output logic [16:0]           quo,
   output blm_pkg::chan_ctl_type ctl_out
);
   import blm_pkg::*;

   // one quotient bit per stage, MSB first
   logic [NUM_BITS-1:0] num_ff [NUM_BITS];
   logic [NUM_BITS-1:0] num_in [NUM_BITS];
   logic [DEN_BITS-1:0] den_ff [NUM_BITS];
   logic [DEN_BITS-1:0] den_in [NUM_BITS];
   logic [DEN_BITS-1:0] rem_ff [NUM_BITS];
   logic [DEN_BITS-1:0] rem_in [NUM_BITS];
   logic [NUM_BITS-1:0] quo_ff [NUM_BITS];
   logic [NUM_BITS-1:0] quo_in [NUM_BITS];
   chan_ctl_type        ctl_ff [NUM_BITS];
   chan_ctl_type        ctl_in [NUM_BITS];

   genvar i;
   generate
      for (i = 0; i < NUM_BITS; i++) begin : g_stage
         logic [NUM_BITS-1:0] n_prev;
         logic [DEN_BITS-1:0] d_prev;
         logic [DEN_BITS-1:0] r_prev;
         logic [NUM_BITS-1:0] q_prev;
         chan_ctl_type        c_prev;
         logic [DEN_BITS:0]   r_shift;
         logic                ge;

         if (i == 0) begin : g_first
            assign n_prev = num;
            assign d_prev = den;
            assign r_prev = '0;
            assign q_prev = '0;
            assign c_prev = ctl;
         end else begin : g_next
            assign n_prev = num_ff[i-1];
            assign d_prev = den_ff[i-1];
            assign r_prev = rem_ff[i-1];
            assign q_prev = quo_ff[i-1];
            assign c_prev = ctl_ff[i-1];
         end

         assign r_shift   = {r_prev, n_prev[NUM_BITS-1-i]};
         assign ge        = (r_shift >= {1'b0, d_prev});
         assign rem_in[i] = ge ? DEN_BITS'(r_shift - {1'b0, d_prev}) : r_shift[DEN_BITS-1:0];
         assign quo_in[i] = {q_prev[NUM_BITS-2:0], ge};
         assign num_in[i] = n_prev;
         assign den_in[i] = d_prev;
         assign ctl_in[i] = c_prev;

         always_ff @(posedge clock) begin
            if (enable) begin
               num_ff[i] <= num_in[i];
               den_ff[i] <= den_in[i];
               rem_ff[i] <= rem_in[i];
               quo_ff[i] <= quo_in[i];
               ctl_ff[i] <= ctl_in[i];
            end
         end
      end
   endgenerate

   assign quo     = quo_ff[NUM_BITS-1];
   assign ctl_out = ctl_ff[NUM_BITS-1];

endmodule

[rtl/blm_post.sv]
module blm_post (
   input  logic [16:0]           quo,
   input  blm_pkg::chan_ctl_type ctl,
   output logic [7:0]            result
);
   import blm_pkg::*;

   logic       big;
   logic [7:0] clamped;
   logic [7:0] inverted;

   assign big      = (quo > 17'd255);
   assign clamped  = big ? 8'd255 : quo[7:0];
   assign inverted = big ? 8'd0 : ~quo[7:0];

   always_comb begin
      case (ctl.op)
         OP_DIRECT:    result = ctl.direct;
         OP_CLAMP:     result = clamped;
         OP_INV:       result = inverted;
         OP_MIX_CLAMP: result = (clamped < 8'd127) ? 8'd0 : 8'd255;
         OP_MIX_INV:   result = (inverted < 8'd127) ? 8'd0 : 8'd255;
         default:      result = ctl.direct;
      endcase
   end

endmodule

[rtl/layer_blend_mode_pixel.sv]
// Channel | Direction | Ports
// req     | in        | req_valid, req_stall, req_base_*, req_blend_*
// rsp     | out       | rsp_valid, rsp_stall, rsp_out_red/green/blue
// csr     | in        | csr_wr_en, csr_wr_data (blend mode)
//
// One pixel per clock unless stalled; stages are one prep stage, 17 restoring
// divider stages (one quotient bit each) and the output register.
// Synchronous reset clears the mode and all valid bits.
// A stalled result freezes the whole pipeline; req_stall follows it.
module layer_blend_mode_pixel (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_base_red,
   input  logic [7:0] req_base_green,
   input  logic [7:0] req_base_blue,
   input  logic [7:0] req_blend_red,
   input  logic [7:0] req_blend_green,
   input  logic [7:0] req_blend_blue,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue
);
   import blm_pkg::*;

   localparam int unsigned VLD_DEPTH = NUM_BITS + 1;

   logic [4:0]           mode_ff;
   logic                 advance;
   logic                 accept;
   logic                 same;
   logic [VLD_DEPTH-1:0] vld_ff;
   logic [VLD_DEPTH-1:0] vld_in;
   logic                 rsp_valid_ff;
   logic [7:0]           out_ff [3];
   logic [7:0]           out_in [3];

   logic [16:0]          num_in [3];
   logic [7:0]           den_in [3];
   chan_ctl_type         ctl_in [3];
   logic [16:0]          num_ff [3];
   logic [7:0]           den_ff [3];
   chan_ctl_type         ctl_ff [3];
   logic [16:0]          quo    [3];
   chan_ctl_type         ctl_q  [3];
   logic [7:0]           base_ch  [3];
   logic [7:0]           blend_ch [3];

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign rsp_valid = rsp_valid_ff;

   assign base_ch[0]  = req_base_red;
   assign base_ch[1]  = req_base_green;
   assign base_ch[2]  = req_base_blue;
   assign blend_ch[0] = req_blend_red;
   assign blend_ch[1] = req_blend_green;
   assign blend_ch[2] = req_blend_blue;
   assign same = (req_base_red == req_blend_red) && (req_base_green == req_blend_green)
              && (req_base_blue == req_blend_blue);

   assign vld_in = {vld_ff[VLD_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) mode_ff <= csr_wr_data;
         if (advance) begin
            vld_ff       <= vld_in;
            rsp_valid_ff <= vld_ff[VLD_DEPTH-1];
         end
      end
   end

   genvar c;
   generate
      for (c = 0; c < 3; c++) begin : g_chan
         blm_prep u_prep (
            .mode (mode_ff),
            .same (same),
            .a    (base_ch[c]),
            .b    (blend_ch[c]),
            .num  (num_in[c]),
            .den  (den_in[c]),
            .ctl  (ctl_in[c])
         );

         always_ff @(posedge clock) begin
            if (advance) begin
               num_ff[c] <= num_in[c];
               den_ff[c] <= den_in[c];
               ctl_ff[c] <= ctl_in[c];
               out_ff[c] <= out_in[c];
            end
         end

         blm_div u_div (
            .clock   (clock),
            .enable  (advance),
            .num     (num_ff[c]),
            .den     (den_ff[c]),
            .ctl     (ctl_ff[c]),
            .quo     (quo[c]),
            .ctl_out (ctl_q[c])
         );

         blm_post u_post (
            .quo    (quo[c]),
            .ctl    (ctl_q[c]),
            .result (out_in[c])
         );
      end
   endgenerate

   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];

`ifndef SYNTHESIS
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> mode_ff == $past(csr_wr_data)) else $error("mode write lost");
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> vld_ff[0]) else $error("request did not enter pipeline");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff)) else $error("pipeline moved while stalled");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (advance && !vld_ff[VLD_DEPTH-1]) |=> !rsp_valid_ff) else $error("invented response");
`endif

endmodule
